// ===== rtl/sepinv_pkg.sv =====
// Shared types, constants and step functions for the 2x2 eigen pseudo-inverse pipeline.
package sepinv_pkg;

  localparam int UNIT_BITS = 30;            // fraction bits of a unit eigenvector component
  localparam int DISC_BITS = 33;            // root bits of the discriminant
  localparam int LEN_BITS  = 35;            // root bits of a column length
  localparam int UDIV_BITS = UNIT_BITS + 1; // quotient bits of a normalisation

  typedef struct packed {
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } mat_t;

  // square root digit state: remainder v - y*y and root so far
  typedef struct packed {
    logic [71:0] rem;
    logic [35:0] y;
  } root_t;

  // sign and magnitude of one candidate column
  typedef struct packed {
    logic        xs;
    logic        ys;
    logic [33:0] xm;
    logic [33:0] ym;
  } svec_t;

  // chosen column, zero when both columns vanish
  typedef struct packed {
    logic        xs;
    logic        ys;
    logic [33:0] xm;
    logic [33:0] ym;
    logic        zero;
  } vsel_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [30:0] q;
  } udiv_t;

  // eigenvalue data that rides along with every word
  typedef struct packed {
    logic signed [33:0] ls;
    logic signed [33:0] ll;
    logic [33:0]        lsm;
    logic [33:0]        llm;
    logic               us;
    logic               ul;
    logic               cplx;
  } side_t;

  typedef struct packed {
    root_t              rt;
    mat_t               m;
    logic signed [32:0] tr;
    logic               cplx;
  } dsec_t;

  typedef struct packed {
    root_t ra;
    root_t rb;
    vsel_t va;
    vsel_t vb;
    side_t sd;
  } lsec_t;

  typedef struct packed {
    udiv_t       ax;
    udiv_t       ay;
    udiv_t       bx;
    udiv_t       by;
    logic [34:0] na;
    logic [34:0] nb;
    logic        axs;
    logic        ays;
    logic        bxs;
    logic        bys;
    logic        za;
    logic        zb;
    side_t       sd;
  } usec_t;

  function automatic root_t root_step(input root_t s, input int b);
    root_t       r;
    logic [71:0] trial;
    r     = s;
    trial = ({36'd0, s.y} << (b + 1)) + (72'd1 << (2 * b));
    if (s.rem >= trial) begin
      r.rem = s.rem - trial;
      r.y   = s.y | (36'd1 << b);
    end
    return r;
  endfunction

  function automatic udiv_t udiv_step(input udiv_t s, input logic [34:0] n, input int i);
    udiv_t       r;
    logic [35:0] w;
    r = s;
    w = s.rem;
    if (w >= {1'b0, n}) begin
      w   = w - {1'b0, n};
      r.q = s.q | (31'd1 << i);
    end
    r.rem = {w[34:0], 1'b0};
    return r;
  endfunction

  function automatic logic [33:0] mag35(input logic signed [34:0] x);
    logic [34:0] n;
    n = -x;
    return x[34] ? n[33:0] : x[33:0];
  endfunction

  function automatic logic [33:0] mag34(input logic signed [33:0] x);
    logic [33:0] n;
    n = -x;
    return x[33] ? n : x;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(x);
  endfunction

endpackage

// ===== rtl/sym2x2_eigen_pseudo_inverse.sv =====
// Pseudo-inverse of a 2x2 matrix through a pipelined closed-form eigendecomposition.
// Takes one matrix word per cycle and returns one result word per cycle. The pipeline has
// 112 + 2*FRAC_BITS register stages (144 at the default), set by the bit-per-stage
// square roots of the discriminant and column lengths, the unit-vector normalisation
// divider and the reciprocal-term divider. The whole pipeline advances together and
// holds when the output word is not taken. The threshold register takes a write in any
// cycle and must only be written while the pipeline is empty.
module sym2x2_eigen_pseudo_inverse
  import sepinv_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] m11,
  input  logic signed [31:0] m12,
  input  logic signed [31:0] m21,
  input  logic signed [31:0] m22,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] p11,
  output logic signed [31:0] p12,
  output logic signed [31:0] p21,
  output logic signed [31:0] p22,
  output logic signed [31:0] eigen_small,
  output logic signed [31:0] eigen_large,
  output logic               complex_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int QB    = 2 * FRAC_BITS + 1;
  localparam int TSH   = 2 * UNIT_BITS - 2 * FRAC_BITS;
  localparam int DEPTH = 3 + DISC_BITS + 6 + LEN_BITS + UDIV_BITS + 2 + QB + 1;

  typedef struct packed {
    logic [QB-1:0] t;
    logic [QB-1:0] q;
    logic [34:0]   rem;
    logic          neg;
  } tdiv_t;

  typedef struct packed {
    tdiv_t [5:0] lane;
    side_t       sd;
  } tsec_t;

  function automatic tdiv_t tdiv_step(input tdiv_t s, input logic [33:0] d, input logic b,
                                      input int i);
    tdiv_t       r;
    logic [34:0] w;
    r = s;
    w = {s.rem[33:0], b};
    if (w >= {1'b0, d}) begin
      w   = w - {1'b0, d};
      r.q = s.q | (QB'(1) << i);
    end
    r.rem = w;
    return r;
  endfunction

  logic [15:0]      small_eigen_threshold;
  logic [DEPTH-1:0] vld;
  logic             adv;

  assign adv       = !vld[DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[DEPTH-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_eigen_threshold <= 16'd1;
    end else if (cfg_valid) begin
      small_eigen_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // ---- trace, difference and magnitudes
  mat_t               s1_m;
  logic signed [32:0] s1_tr;
  logic [32:0]        s1_amag;
  logic [31:0]        s1_mag12;
  logic [31:0]        s1_mag21;
  logic               s1_neg;

  always_ff @(posedge clk) begin
    logic signed [32:0] diff;
    logic [32:0]        ndiff;
    diff  = 33'(m11) - 33'(m22);
    ndiff = -diff;
    if (adv) begin
      s1_m     <= '{m11: m11, m12: m12, m21: m21, m22: m22};
      s1_tr    <= 33'(m11) + 33'(m22);
      s1_amag  <= diff[32] ? ndiff : diff;
      s1_mag12 <= m12[31] ? -m12 : m12;
      s1_mag21 <= m21[31] ? -m21 : m21;
      s1_neg   <= (m12[31] != m21[31]) && (m12 != 32'sd0) && (m21 != 32'sd0);
    end
  end

  mat_t               s2_m;
  logic signed [32:0] s2_tr;
  logic [65:0]        s2_sq;
  logic [63:0]        s2_pm;
  logic               s2_neg;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_m   <= s1_m;
      s2_tr  <= s1_tr;
      s2_sq  <= s1_amag * s1_amag;
      s2_pm  <= s1_mag12 * s1_mag21;
      s2_neg <= s1_neg;
    end
  end

  // ---- discriminant, clamped at zero
  mat_t               s3_m;
  logic signed [32:0] s3_tr;
  logic [66:0]        s3_disc;
  logic               s3_cplx;

  always_ff @(posedge clk) begin
    logic [65:0] four;
    four = {s2_pm, 2'b00};
    if (adv) begin
      s3_m  <= s2_m;
      s3_tr <= s2_tr;
      if (!s2_neg) begin
        s3_disc <= {1'b0, s2_sq} + {1'b0, four};
        s3_cplx <= 1'b0;
      end else if (s2_sq >= four) begin
        s3_disc <= {1'b0, s2_sq - four};
        s3_cplx <= 1'b0;
      end else begin
        s3_disc <= '0;
        s3_cplx <= 1'b1;
      end
    end
  end

  // ---- gap = floor(sqrt(disc)), one bit a stage
  dsec_t d_sec [0:DISC_BITS-1];

  for (genvar k = 0; k < DISC_BITS; k++) begin : g_disc
    dsec_t prev;
    dsec_t nxt;
    if (k == 0) begin : g_head
      assign prev = '{rt: '{rem: {5'd0, s3_disc}, y: '0}, m: s3_m, tr: s3_tr, cplx: s3_cplx};
    end else begin : g_body
      assign prev = d_sec[k-1];
    end
    always_comb begin
      nxt    = prev;
      nxt.rt = root_step(prev.rt, DISC_BITS - 1 - k);
    end
    always_ff @(posedge clk) begin
      if (adv) d_sec[k] <= nxt;
    end
  end

  // ---- eigenvalues
  mat_t               e_m;
  logic signed [33:0] e_ls;
  logic signed [33:0] e_ll;
  logic               e_cplx;

  always_ff @(posedge clk) begin
    logic signed [34:0] tr35;
    logic signed [34:0] gap35;
    logic signed [34:0] dn;
    logic signed [34:0] up;
    tr35  = 35'(d_sec[DISC_BITS-1].tr);
    gap35 = $signed({2'b00, d_sec[DISC_BITS-1].rt.y[32:0]});
    dn    = tr35 - gap35;
    up    = tr35 + gap35;
    if (adv) begin
      e_m    <= d_sec[DISC_BITS-1].m;
      e_ls   <= dn[34:1];
      e_ll   <= up[34:1];
      e_cplx <= d_sec[DISC_BITS-1].cplx;
    end
  end

  // ---- columns of A - lambda*I and reciprocal enables
  logic signed [34:0] f_col [0:7];
  side_t              f_sd;

  always_ff @(posedge clk) begin
    logic [33:0] lsm;
    logic [33:0] llm;
    lsm = mag34(e_ls);
    llm = mag34(e_ll);
    if (adv) begin
      // vector a from eigen_large, vector b from eigen_small
      f_col[0] <= 35'(e_m.m11) - 35'(e_ll);
      f_col[1] <= 35'(e_m.m21);
      f_col[2] <= 35'(e_m.m12);
      f_col[3] <= 35'(e_m.m22) - 35'(e_ll);
      f_col[4] <= 35'(e_m.m11) - 35'(e_ls);
      f_col[5] <= 35'(e_m.m21);
      f_col[6] <= 35'(e_m.m12);
      f_col[7] <= 35'(e_m.m22) - 35'(e_ls);
      f_sd     <= '{ls: e_ls, ll: e_ll, lsm: lsm, llm: llm,
                    us: (e_ls != 34'sd0) && (lsm >= {18'd0, small_eigen_threshold}),
                    ul: (e_ll != 34'sd0) && (llm >= {18'd0, small_eigen_threshold}),
                    cplx: e_cplx};
    end
  end

  svec_t g_v [0:3];
  side_t g_sd;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        g_v[c] <= '{xs: f_col[2*c][34], ys: f_col[2*c+1][34],
                    xm: mag35(f_col[2*c]), ym: mag35(f_col[2*c+1])};
      end
      g_sd <= f_sd;
    end
  end

  svec_t       h_v [0:3];
  logic [67:0] h_sq [0:7];
  side_t       h_sd;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        h_v[c]      <= g_v[c];
        h_sq[2*c]   <= g_v[c].xm * g_v[c].xm;
        h_sq[2*c+1] <= g_v[c].ym * g_v[c].ym;
      end
      h_sd <= g_sd;
    end
  end

  svec_t       i_v [0:3];
  logic [68:0] i_len [0:3];
  side_t       i_sd;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        i_v[c]   <= h_v[c];
        i_len[c] <= {1'b0, h_sq[2*c]} + {1'b0, h_sq[2*c+1]};
      end
      i_sd <= h_sd;
    end
  end

  // ---- longer column; ties go to the second
  vsel_t       j_va;
  vsel_t       j_vb;
  logic [68:0] j_la;
  logic [68:0] j_lb;
  side_t       j_sd;

  always_ff @(posedge clk) begin
    svec_t       a;
    svec_t       b;
    logic [68:0] la;
    logic [68:0] lb;
    a  = (i_len[0] > i_len[1]) ? i_v[0] : i_v[1];
    la = (i_len[0] > i_len[1]) ? i_len[0] : i_len[1];
    b  = (i_len[2] > i_len[3]) ? i_v[2] : i_v[3];
    lb = (i_len[2] > i_len[3]) ? i_len[2] : i_len[3];
    if (adv) begin
      j_va <= '{xs: a.xs, ys: a.ys, xm: a.xm, ym: a.ym, zero: (la == '0)};
      j_vb <= '{xs: b.xs, ys: b.ys, xm: b.xm, ym: b.ym, zero: (lb == '0)};
      j_la <= la;
      j_lb <= lb;
      j_sd <= i_sd;
    end
  end

  // ---- column norms, one bit a stage
  lsec_t l_sec [0:LEN_BITS-1];

  for (genvar k = 0; k < LEN_BITS; k++) begin : g_len
    lsec_t prev;
    lsec_t nxt;
    if (k == 0) begin : g_head
      assign prev = '{ra: '{rem: {3'd0, j_la}, y: '0}, rb: '{rem: {3'd0, j_lb}, y: '0},
                      va: j_va, vb: j_vb, sd: j_sd};
    end else begin : g_body
      assign prev = l_sec[k-1];
    end
    always_comb begin
      nxt    = prev;
      nxt.ra = root_step(prev.ra, LEN_BITS - 1 - k);
      nxt.rb = root_step(prev.rb, LEN_BITS - 1 - k);
    end
    always_ff @(posedge clk) begin
      if (adv) l_sec[k] <= nxt;
    end
  end

  // ---- normalisation: |c| * 2^30 / norm, one quotient bit a stage
  usec_t u_sec [0:UDIV_BITS-1];

  for (genvar k = 0; k < UDIV_BITS; k++) begin : g_unit
    usec_t prev;
    usec_t nxt;
    if (k == 0) begin : g_head
      lsec_t lt;
      assign lt   = l_sec[LEN_BITS-1];
      assign prev = '{ax: '{rem: {2'd0, lt.va.xm}, q: '0}, ay: '{rem: {2'd0, lt.va.ym}, q: '0},
                      bx: '{rem: {2'd0, lt.vb.xm}, q: '0}, by: '{rem: {2'd0, lt.vb.ym}, q: '0},
                      na: lt.ra.y[34:0], nb: lt.rb.y[34:0],
                      axs: lt.va.xs, ays: lt.va.ys, bxs: lt.vb.xs, bys: lt.vb.ys,
                      za: lt.va.zero, zb: lt.vb.zero, sd: lt.sd};
    end else begin : g_body
      assign prev = u_sec[k-1];
    end
    always_comb begin
      nxt    = prev;
      nxt.ax = udiv_step(prev.ax, prev.na, UDIV_BITS - 1 - k);
      nxt.ay = udiv_step(prev.ay, prev.na, UDIV_BITS - 1 - k);
      nxt.bx = udiv_step(prev.bx, prev.nb, UDIV_BITS - 1 - k);
      nxt.by = udiv_step(prev.by, prev.nb, UDIV_BITS - 1 - k);
    end
    always_ff @(posedge clk) begin
      if (adv) u_sec[k] <= nxt;
    end
  end

  // ---- unit vectors, axis vectors for a scalar matrix
  logic [30:0] k_m [0:3];
  logic        k_s [0:3];
  side_t       k_sd;

  always_ff @(posedge clk) begin
    usec_t ut;
    ut = u_sec[UDIV_BITS-1];
    if (adv) begin
      k_m[0] <= ut.za ? (31'd1 << UNIT_BITS) : ut.ax.q;
      k_m[1] <= ut.za ? 31'd0 : ut.ay.q;
      k_m[2] <= ut.zb ? 31'd0 : ut.bx.q;
      k_m[3] <= ut.zb ? (31'd1 << UNIT_BITS) : ut.by.q;
      k_s[0] <= !ut.za && ut.axs;
      k_s[1] <= !ut.za && ut.ays;
      k_s[2] <= !ut.zb && ut.bxs;
      k_s[3] <= !ut.zb && ut.bys;
      k_sd   <= ut.sd;
    end
  end

  // ---- outer products, pre-scaled so the divide yields FRAC_BITS fraction bits
  logic [QB-1:0] l_t [0:5];
  logic          l_neg [0:5];
  side_t         l_sd;

  always_ff @(posedge clk) begin
    logic [61:0] pr [0:5];
    pr[0] = k_m[0] * k_m[0];
    pr[1] = k_m[0] * k_m[1];
    pr[2] = k_m[1] * k_m[1];
    pr[3] = k_m[2] * k_m[2];
    pr[4] = k_m[2] * k_m[3];
    pr[5] = k_m[3] * k_m[3];
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        l_t[j] <= pr[j][2*UNIT_BITS:TSH];
      end
      l_neg[0] <= k_sd.ls[33];
      l_neg[1] <= k_s[0] ^ k_s[1] ^ k_sd.ls[33];
      l_neg[2] <= k_sd.ls[33];
      l_neg[3] <= k_sd.ll[33];
      l_neg[4] <= k_s[2] ^ k_s[3] ^ k_sd.ll[33];
      l_neg[5] <= k_sd.ll[33];
      l_sd     <= k_sd;
    end
  end

  // ---- reciprocal terms, one quotient bit a stage
  tsec_t t_sec [0:QB-1];

  for (genvar k = 0; k < QB; k++) begin : g_term
    tsec_t prev;
    tsec_t nxt;
    if (k == 0) begin : g_head
      always_comb begin
        for (int j = 0; j < 6; j++) begin
          prev.lane[j] = '{t: l_t[j], q: '0, rem: '0, neg: l_neg[j]};
        end
        prev.sd = l_sd;
      end
    end else begin : g_body
      assign prev = t_sec[k-1];
    end
    always_comb begin
      nxt = prev;
      for (int j = 0; j < 6; j++) begin
        nxt.lane[j] = tdiv_step(prev.lane[j], (j < 3) ? prev.sd.lsm : prev.sd.llm,
                                prev.lane[j].t[QB-1-k], QB - 1 - k);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) t_sec[k] <= nxt;
    end
  end

  // ---- signed terms, sums and saturation
  always_ff @(posedge clk) begin
    tsec_t              tt;
    logic signed [QB:0] tv [0:5];
    logic signed [QB+1:0] s11;
    logic signed [QB+1:0] s12;
    logic signed [QB+1:0] s22;
    tt = t_sec[QB-1];
    for (int j = 0; j < 6; j++) begin
      if ((j < 3) ? !tt.sd.us : !tt.sd.ul) begin
        tv[j] = '0;
      end else if (tt.lane[j].neg) begin
        tv[j] = -$signed({1'b0, tt.lane[j].q});
      end else begin
        tv[j] = $signed({1'b0, tt.lane[j].q});
      end
    end
    s11 = (QB+2)'(tv[0]) + (QB+2)'(tv[3]);
    s12 = (QB+2)'(tv[1]) + (QB+2)'(tv[4]);
    s22 = (QB+2)'(tv[2]) + (QB+2)'(tv[5]);
    if (adv) begin
      p11          <= sat32(64'(s11));
      p12          <= sat32(64'(s12));
      p21          <= sat32(64'(s12));
      p22          <= sat32(64'(s22));
      eigen_small  <= sat32(64'(tt.sd.ls));
      eigen_large  <= sat32(64'(tt.sd.ll));
      complex_flag <= tt.sd.cplx;
    end
  end

endmodule

// ===== tb/sym2x2_eigen_pseudo_inverse_checker.sv =====
// Checker for the 2x2 eigen pseudo-inverse: predicts each result word and compares it.
module sym2x2_eigen_pseudo_inverse_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] m11,
  input  logic signed [31:0] m12,
  input  logic signed [31:0] m21,
  input  logic signed [31:0] m22,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] p11,
  input  logic signed [31:0] p12,
  input  logic signed [31:0] p21,
  input  logic signed [31:0] p22,
  input  logic signed [31:0] eigen_small,
  input  logic signed [31:0] eigen_large,
  input  logic               complex_flag,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam int FRAC_BITS = 16;
  localparam int UNIT_BITS = 30;

  typedef logic [127:0] u128_t;

  typedef struct {
    logic signed [31:0] p11;
    logic signed [31:0] p12;
    logic signed [31:0] p21;
    logic signed [31:0] p22;
    logic signed [31:0] ev_lo;
    logic signed [31:0] ev_hi;
    logic               cplx;
  } pinv_t;

  pinv_t       pinv_q[$];
  logic [15:0] threshold;

  function automatic u128_t mag(input longint x);
    return x < 0 ? u128_t'(-x) : u128_t'(x);
  endfunction

  function automatic u128_t isqrt(input u128_t v);
    u128_t y, c;
    y = 0;
    for (int b = 63; b >= 0; b--) begin
      c = y | (u128_t'(1) << b);
      if (c * c <= v) y = c;
    end
    return y;
  endfunction

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic longint unit_comp(input longint c, input u128_t n);
    longint u;
    u = longint'(((mag(c) << UNIT_BITS) / n));
    return c < 0 ? -u : u;
  endfunction

  // longer column of (cx,cy) and (dx,dy), normalised; axis vector when both vanish
  function automatic void eigvec(input longint cx, input longint cy, input longint dx,
                                 input longint dy, input bit axis,
                                 output longint vx, output longint vy);
    u128_t  l0, l1, l, n;
    longint x, y;
    l0 = mag(cx) * mag(cx) + mag(cy) * mag(cy);
    l1 = mag(dx) * mag(dx) + mag(dy) * mag(dy);
    if (l0 > l1) begin
      x = cx; y = cy; l = l0;
    end else begin
      x = dx; y = dy; l = l1;
    end
    if (l == 0) begin
      vx = axis ? 0 : (longint'(1) << UNIT_BITS);
      vy = axis ? (longint'(1) << UNIT_BITS) : 0;
    end else begin
      n  = isqrt(l);
      vx = unit_comp(x, n);
      vy = unit_comp(y, n);
    end
  endfunction

  function automatic longint recip_term(input longint t, input longint lam, input bit en);
    u128_t  q;
    longint r;
    if (!en || t == 0) return 0;
    q = ((mag(t) << (2 * FRAC_BITS)) / mag(lam)) >> (2 * UNIT_BITS);
    r = longint'(q[63:0]);
    return ((t < 0) != (lam < 0)) ? -r : r;
  endfunction

  function automatic pinv_t predict_pinv(input longint a11, input longint a12,
                                         input longint a21, input longint a22,
                                         input logic [15:0] thr);
    pinv_t  r;
    longint tr, dm, gap, ls, ll, ax, ay, bx, by, s11, s12, s22;
    u128_t  pm, sq, four, disc;
    bit     neg, cplx, us, ul;
    tr   = a11 + a22;
    dm   = a11 - a22;
    pm   = mag(a12) * mag(a21);
    neg  = ((a12 < 0) != (a21 < 0)) && pm != 0;
    sq   = mag(dm) * mag(dm);
    four = pm << 2;
    cplx = 0;
    if (!neg) disc = sq + four;
    else if (sq >= four) disc = sq - four;
    else begin
      disc = 0;
      cplx = 1;
    end
    gap = longint'(isqrt(disc));
    ls  = (tr - gap) >>> 1;
    ll  = (tr + gap) >>> 1;
    eigvec(a11 - ll, a21, a12, a22 - ll, 1'b0, ax, ay);
    eigvec(a11 - ls, a21, a12, a22 - ls, 1'b1, bx, by);
    us  = ls != 0 && mag(ls) >= u128_t'(thr);
    ul  = ll != 0 && mag(ll) >= u128_t'(thr);
    s11 = recip_term(ax * ax, ls, us) + recip_term(bx * bx, ll, ul);
    s12 = recip_term(ax * ay, ls, us) + recip_term(bx * by, ll, ul);
    s22 = recip_term(ay * ay, ls, us) + recip_term(by * by, ll, ul);
    r.p11   = clip32(s11);
    r.p12   = clip32(s12);
    r.p21   = clip32(s12);
    r.p22   = clip32(s22);
    r.ev_lo = clip32(ls);
    r.ev_hi = clip32(ll);
    r.cplx  = cplx;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    pinv_t e;
    if (rst) begin
      threshold = 16'd1;
      pinv_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (in_valid && in_ready)
        pinv_q.push_back(predict_pinv(longint'(m11), longint'(m12), longint'(m21),
                                      longint'(m22), threshold));
      if (out_valid && out_ready) begin
        if (pinv_q.size() == 0) begin
          $error("result word with no matrix outstanding");
          errors++;
        end else begin
          e = pinv_q.pop_front();
          check_field("p11", e.p11, p11);
          check_field("p12", e.p12, p12);
          check_field("p21", e.p21, p21);
          check_field("p22", e.p22, p22);
          check_field("eigen_small", e.ev_lo, eigen_small);
          check_field("eigen_large", e.ev_hi, eigen_large);
          check_field("complex_flag", 32'(e.cplx), 32'(complex_flag));
        end
      end
    end
    pending <= pinv_q.size();
  end

endmodule

// ===== tb/sym2x2_eigen_pseudo_inverse_test.sv =====
// Top of the 2x2 eigen pseudo-inverse testbench: matrix stimulus, threshold phases, verdict.
module sym2x2_eigen_pseudo_inverse_test;
  import sepinv_pkg::*;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] m11, m12, m21, m22;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] p11, p12, p21, p22;
  logic signed [31:0] eigen_small, eigen_large;
  logic               complex_flag;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;
  int                 errors;
  int                 pending;
  bit                 calm;

  sym2x2_eigen_pseudo_inverse DUT (.*);

  sym2x2_eigen_pseudo_inverse_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sym2x2_eigen_pseudo_inverse_test: errors");
    $finish;
  end

  // result side: stall bursts until the quiet tail
  initial begin
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 3) != 0) begin
        out_ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 0;
        repeat ($urandom_range(0, 17)) @(posedge clk);
      end
    end
  end

  task automatic send_matrix(input mat_t m);
    in_valid <= 1;
    m11 <= m.m11;
    m12 <= m.m12;
    m21 <= m.m21;
    m22 <= m.m22;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic signed [31:0] mk(input logic signed [31:0] a,
                                            input logic signed [31:0] b,
                                            input logic signed [31:0] c,
                                            input logic signed [31:0] d, output mat_t m);
    m.m11 = a; m.m12 = b; m.m21 = c; m.m22 = d;
    return a;
  endfunction

  function automatic logic signed [31:0] rnd_entry(input int span);
    logic signed [31:0] v;
    v = $urandom();
    return span >= 32 ? v : (v >>> (32 - span));
  endfunction

  function automatic mat_t rnd_matrix;
    mat_t               m;
    int                 span;
    logic signed [31:0] a, b, c;
    span = $urandom_range(0, 3) == 0 ? 32 : $urandom_range(4, 24);
    a    = rnd_entry(span);
    b    = rnd_entry(span);
    c    = rnd_entry(span);
    case ($urandom_range(0, 9))
      0, 1: void'(mk(a, b, c, rnd_entry(span), m));
      2, 3: void'(mk(a, b, b, c, m));                  // symmetric, real eigenvalues
      4:    void'(mk(a, 0, 0, a, m));                  // scalar
      5:    void'(mk(a, 0, 0, c, m));                  // diagonal
      6:    void'(mk(a, b, a, b, m));                  // rank one, zero eigenvalue
      7:    void'(mk(a, b, -b, c, m));                 // usually complex
      8:    void'(mk(rnd_entry(18), 0, 0, ONE, m));    // eigenvalue near threshold
      default: void'(mk($urandom(), $urandom(), $urandom(), $urandom(), m));
    endcase
    return m;
  endfunction

  task automatic random_items(input int n);
    repeat (n) send_matrix(rnd_matrix());
  endtask

  initial begin
    mat_t m;
    calm      = 0;
    rst       = 1;
    in_valid  = 0;
    m11       = 0;
    m12       = 0;
    m21       = 0;
    m22       = 0;
    cfg_valid = 0;
    cfg_data  = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes and special cases at the reset threshold
    void'(mk(0, 0, 0, 0, m));             send_matrix(m);
    void'(mk(SMAX, SMAX, SMAX, SMAX, m)); send_matrix(m);
    void'(mk(SMIN, SMIN, SMIN, SMIN, m)); send_matrix(m);
    void'(mk(SMAX, SMIN, SMIN, SMAX, m)); send_matrix(m);
    void'(mk(SMIN, SMAX, SMIN, SMAX, m)); send_matrix(m);
    void'(mk(SMAX, SMAX, SMIN, SMIN, m)); send_matrix(m);
    void'(mk(ONE, 0, 0, ONE, m));         send_matrix(m);
    void'(mk(5, 0, 0, 5, m));             send_matrix(m);
    void'(mk(-ONE, 0, 0, -ONE, m));       send_matrix(m);
    void'(mk(1, 0, 0, 0, m));             send_matrix(m);
    void'(mk(0, ONE, -ONE, 0, m));        send_matrix(m);
    void'(mk(0, SMAX, SMIN, 0, m));       send_matrix(m);
    void'(mk(2 * ONE, ONE, ONE, 2 * ONE, m)); send_matrix(m);
    void'(mk(ONE, 2 * ONE, ONE, 2 * ONE, m)); send_matrix(m);
    void'(mk(3 * ONE, -ONE, 4 * ONE, -2 * ONE, m)); send_matrix(m);
    void'(mk(ONE, 0, 0, -ONE, m));        send_matrix(m);
    void'(mk(-1, -1, -1, -1, m));         send_matrix(m);
    void'(mk(1, 1, 1, 1, m));             send_matrix(m);
    void'(mk(0, 7, 0, 0, m));             send_matrix(m);

    random_items(150);
    write_threshold(16'd0);
    void'(mk(1, 0, 0, 0, m));             send_matrix(m);
    random_items(150);
    write_threshold(16'hFFFF);
    void'(mk(32'sh0000_FFFF, 0, 0, 32'sh0001_0000, m)); send_matrix(m);
    random_items(150);
    write_threshold(16'h0100);
    void'(mk(32'sh0000_0100, 0, 0, 32'sh0000_00FF, m)); send_matrix(m);
    random_items(150);
    write_threshold(16'($urandom()));
    random_items(200);
    write_threshold(16'd1);
    drain();
    calm = 1;
    random_items(200);
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0) $display("sym2x2_eigen_pseudo_inverse_test: clean");
    else $display("sym2x2_eigen_pseudo_inverse_test: errors");
    $finish;
  end

endmodule
